// ===== sv/iqmc_pkg.sv =====
// iqmc_pkg: shared constants for the iq magnitude clipper
// register map, gain format and default sample width; no dependencies
package iqmc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int GAIN_W          = 24;
    localparam int GAIN_FRAC       = 16;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    localparam logic [APB_AW-1:0] ADDR_ENABLE = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_GAIN   = 3'd4;

endpackage

// ===== sv/iq_magnitude_clipper_unit.sv =====
// iq_magnitude_clipper_unit: complex envelope hard clipper, top level
// uses iqmc_pkg and iqmc_root_stage
//
// channel   dir  handshake                  payload
// s_axis    in   tvalid/tready              tdata {in_q, in_i}, tlast in_last
// m_axis    out  tvalid/tready              tdata {out_q, out_i}, tlast out_last
// apb       in   psel/penable/pwrite/pready enable @0, gain_linear @4
//
// one request per clock while the output is not stalled; four setup stages,
// one quotient stage per result bit, one output stage
// the quotient chain sets the depth; the widest multipliers, 24x32, form the gain-squared times power product
// reset clears the valid bits and the configuration registers; a stalled output holds the whole pipe
module iq_magnitude_clipper_unit #(
    parameter int SAMPLE_BITS = iqmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata, // in_i, in_q
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata, // out_i, out_q
    output logic                          o_m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iqmc_pkg::APB_AW-1:0]   paddr,
    input  logic [iqmc_pkg::APB_DW-1:0]   pwdata,
    output logic [iqmc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int F      = SB - 1;
    localparam int GW     = iqmc_pkg::GAIN_W;
    localparam int DATA_W = ((2 * SB + 7) / 8) * 8;
    localparam int SW     = 2 * SB;
    localparam int DW     = 4 * SB + 4;
    localparam int NW     = SB;
    localparam int MW     = SB + 9;
    localparam int PW     = 2 * GW + SW;
    localparam int SIDE_W = 3 + 2 * SB + MW;

    // configuration
    logic          r_enable;
    logic [GW-1:0] r_gain;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_gain   <= iqmc_pkg::GAIN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                iqmc_pkg::ADDR_ENABLE: r_enable <= pwdata[0];
                iqmc_pkg::ADDR_GAIN:   r_gain   <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            iqmc_pkg::ADDR_ENABLE: prdata = {{(iqmc_pkg::APB_DW-1){1'b0}}, r_enable};
            iqmc_pkg::ADDR_GAIN:   prdata = {{(iqmc_pkg::APB_DW-GW){1'b0}}, r_gain};
            default:               prdata = '0;
        endcase
    end

    // pipe advance
    logic r_out_valid;
    logic en;
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: magnitudes and products
    logic [SB-1:0] in_i, in_q, abs_i, abs_q;
    assign in_i  = i_s_axis_tdata[SB-1:0];
    assign in_q  = i_s_axis_tdata[2*SB-1:SB];
    assign abs_i = in_i[SB-1] ? (~in_i + SB'(1)) : in_i;
    assign abs_q = in_q[SB-1] ? (~in_q + SB'(1)) : in_q;

    logic               r1_valid, r1_last;
    logic [SB-1:0]      r1_i, r1_q;
    logic [2*SB-1:0]    r1_sqi, r1_sqq;
    logic [2*GW-1:0]    r1_g2;
    logic [SB+GW-1:0]   r1_pg;

    // stage 2
    logic               r2_valid, r2_last;
    logic [SB-1:0]      r2_i, r2_q;
    logic [SW-1:0]      r2_s;
    logic [2*SB-1:0]    r2_sqi;
    logic [2*GW-1:0]    r2_g2;
    logic [MW-1:0]      r2_small;
    logic [SB+GW:0]     pg_round;
    assign pg_round = {1'b0, r1_pg} + (SB+GW+1)'(1 << (iqmc_pkg::GAIN_FRAC - 1));

    // stage 3
    logic               r3_valid, r3_last;
    logic [SB-1:0]      r3_i, r3_q;
    logic [SW-1:0]      r3_s;
    logic [2*SB-1:0]    r3_sqi;
    logic [MW-1:0]      r3_small;
    logic [GW+SW-1:0]   r3_ph, r3_pl;

    // stage 4
    logic               r4_valid;
    logic [SIDE_W-1:0]  r4_side;
    logic [SW-1:0]      r4_s;
    logic signed [DW-1:0] r4_d, r4_w;
    logic [PW-1:0]      p_full;
    logic               clip;
    assign p_full = (PW'(r3_ph) << GW) + PW'(r3_pl);
    assign clip   = (r3_s != '0) && (p_full > (PW'(1) << (32 + 2 * F)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_s_axis_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_last  <= i_s_axis_tlast;
            r1_i     <= in_i;
            r1_q     <= in_q;
            r1_sqi   <= abs_i * abs_i;
            r1_sqq   <= abs_q * abs_q;
            r1_g2    <= r_gain * r_gain;
            r1_pg    <= abs_i * r_gain;

            r2_last  <= r1_last;
            r2_i     <= r1_i;
            r2_q     <= r1_q;
            r2_s     <= r1_sqi + r1_sqq;
            r2_sqi   <= r1_sqi;
            r2_g2    <= r1_g2;
            r2_small <= pg_round[SB+GW:iqmc_pkg::GAIN_FRAC];

            r3_last  <= r2_last;
            r3_i     <= r2_i;
            r3_q     <= r2_q;
            r3_s     <= r2_s;
            r3_sqi   <= r2_sqi;
            r3_small <= r2_small;
            r3_ph    <= r2_g2[2*GW-1:GW] * r2_s;
            r3_pl    <= r2_g2[GW-1:0] * r2_s;

            r4_side  <= {clip, r3_i[SB-1], r3_last, r3_q, r3_i, r3_small};
            r4_s     <= r3_s;
            r4_d     <= $signed(DW'(r3_sqi) << (2 * SB)) - $signed(DW'(r3_s));
            r4_w     <= -$signed(DW'(r3_s));
        end
    end

    // quotient chain, one bit per stage from the top
    logic                 c_valid [0:SB];
    logic [SIDE_W-1:0]    c_side  [0:SB];
    logic [SW-1:0]        c_s     [0:SB];
    logic signed [DW-1:0] c_d     [0:SB];
    logic signed [DW-1:0] c_w     [0:SB];
    logic [NW-1:0]        c_n     [0:SB];

    assign c_valid[0] = r4_valid;
    assign c_side[0]  = r4_side;
    assign c_s[0]     = r4_s;
    assign c_d[0]     = r4_d;
    assign c_w[0]     = r4_w;
    assign c_n[0]     = '0;

    for (genvar k = 0; k < SB; k++) begin : g_root
        iqmc_root_stage #(
            .BIT    (F - k),
            .SIDE_W (SIDE_W),
            .SW     (SW),
            .DW     (DW),
            .NW     (NW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[k]),
            .i_side  (c_side[k]),
            .i_s     (c_s[k]),
            .i_d     (c_d[k]),
            .i_w     (c_w[k]),
            .i_n     (c_n[k]),
            .o_valid (c_valid[k+1]),
            .o_side  (c_side[k+1]),
            .o_s     (c_s[k+1]),
            .o_d     (c_d[k+1]),
            .o_w     (c_w[k+1]),
            .o_n     (c_n[k+1])
        );
    end

    // output stage: select, sign, saturate, or pass the input through when disabled
    logic [SIDE_W-1:0]    fin;
    logic [MW-1:0]        mag;
    logic signed [MW:0]   sval;
    logic [SB-1:0]        sat_i, res_i, res_q;
    logic                 fin_clip, fin_neg, fin_last;
    logic [SB-1:0]        fin_i, fin_q;

    assign fin      = c_side[SB];
    assign fin_clip = fin[SIDE_W-1];
    assign fin_neg  = fin[SIDE_W-2];
    assign fin_last = fin[SIDE_W-3];
    assign fin_q    = fin[MW+2*SB-1:MW+SB];
    assign fin_i    = fin[MW+SB-1:MW];
    assign mag      = fin_clip ? MW'(c_n[SB]) : fin[MW-1:0];
    assign sval     = fin_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_comb begin
        if (sval > $signed((MW+1)'((1 << F) - 1))) begin
            sat_i = {1'b0, {(SB-1){1'b1}}};
        end else if (sval < -$signed((MW+1)'(1 << F))) begin
            sat_i = {1'b1, {(SB-1){1'b0}}};
        end else begin
            sat_i = sval[SB-1:0];
        end
        res_i = r_enable ? sat_i : fin_i;
        res_q = r_enable ? '0 : fin_q;
    end

    logic [2*SB-1:0] r_out_data;
    logic            r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid[SB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {res_q, res_i};
            r_out_last <= fin_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_W'(r_out_data);
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== sv/iqmc_root_stage.sv =====
// iqmc_root_stage: one bit of the rounded i/magnitude quotient
// shift-and-add restoring step, no multipliers; uses no package items
module iqmc_root_stage #(
    parameter int BIT    = 0,
    parameter int SIDE_W = 8,
    parameter int SW     = 32,
    parameter int DW     = 68,
    parameter int NW     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SIDE_W-1:0]    i_side,
    input  logic [SW-1:0]        i_s,
    input  logic signed [DW-1:0] i_d,
    input  logic signed [DW-1:0] i_w,
    input  logic [NW-1:0]        i_n,
    output logic                 o_valid,
    output logic [SIDE_W-1:0]    o_side,
    output logic [SW-1:0]        o_s,
    output logic signed [DW-1:0] o_d,
    output logic signed [DW-1:0] o_w,
    output logic [NW-1:0]        o_n
);

    logic                 r_valid;
    logic [SIDE_W-1:0]    r_side;
    logic [SW-1:0]        r_s;
    logic signed [DW-1:0] r_d, r_w;
    logic [NW-1:0]        r_n;

    logic signed [DW-1:0] s_ext, term, d_try;
    logic                 take;

    assign s_ext = $signed({{(DW-SW){1'b0}}, i_s});
    assign term  = (i_w <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
    assign d_try = i_d - term;
    assign take  = ~d_try[DW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_s    <= i_s;
            if (take) begin
                r_d <= d_try;
                r_w <= i_w + (s_ext <<< (BIT + 1));
                r_n <= i_n | (NW'(1) << BIT);
            end else begin
                r_d <= i_d;
                r_w <= i_w;
                r_n <= i_n;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_s     = r_s;
    assign o_d     = r_d;
    assign o_w     = r_w;
    assign o_n     = r_n;

endmodule

// ===== verif/iqmc_checker.sv =====
// iqmc_checker: watches the sample channels of the iq magnitude clipper, predicts each
// output sample and compares it field by field; stand-alone, no package items
module iqmc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_clip_en,
    input  logic [23:0] i_gain,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        last;
        logic [15:0] q;
        logic [15:0] i;
    } t_sample;

    t_sample clipped_q[$];

    function automatic logic [15:0] clip_sample(logic signed [15:0] si,
                                                logic signed [15:0] sq,
                                                logic en, logic [23:0] g);
        logic [127:0] ai, aq, pw, lhs, lim, n, c, t, rhs;
        longint       mag, v;
        if (!en) return si;
        ai  = (si < 0) ? -si : si;
        aq  = (sq < 0) ? -sq : sq;
        pw  = ai * ai + aq * aq;
        lhs = g * g * pw;
        lim = 128'd1 << 62;
        if (pw != 0 && lhs > lim) begin
            // largest n with (2n-1)^2 * pw <= (2^16 * ai)^2
            rhs = (ai << 16) * (ai << 16);
            n = 0;
            for (int b = 15; b >= 0; b--) begin
                c = n | (128'd1 << b);
                t = 2 * c - 1;
                if (t * t * pw <= rhs) n = c;
            end
            mag = longint'(n);
        end else begin
            mag = longint'((ai * g + 32768) >> 16);
        end
        v = (si < 0) ? -mag : mag;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    always @(posedge i_clk) begin
        t_sample exp_s, got;
        int      nerr;
        nerr = 0;
        if (!i_rst_n) begin
            clipped_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                exp_s.i    = clip_sample(i_s_tdata[15:0], i_s_tdata[31:16], i_clip_en, i_gain);
                exp_s.q    = i_clip_en ? 16'd0 : i_s_tdata[31:16];
                exp_s.last = i_s_tlast;
                clipped_q.push_back(exp_s);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tlast, i_m_tdata[31:16], i_m_tdata[15:0]};
                if (clipped_q.size() == 0) begin
                    $error("output sample with none expected");
                    nerr = nerr + 1;
                end else begin
                    exp_s = clipped_q.pop_front();
                    if (got.i !== exp_s.i) begin
                        $error("out_i expected %0d got %0d",
                               $signed(exp_s.i), $signed(got.i));
                        nerr = nerr + 1;
                    end
                    if (got.q !== exp_s.q) begin
                        $error("out_q expected %0d got %0d",
                               $signed(exp_s.q), $signed(got.q));
                        nerr = nerr + 1;
                    end
                    if (got.last !== exp_s.last) begin
                        $error("out_last expected %0d got %0d", exp_s.last, got.last);
                        nerr = nerr + 1;
                    end
                end
            end
            o_errors  <= o_errors + nerr;
            o_pending <= clipped_q.size();
        end
    end
endmodule

// ===== verif/tb_iq_magnitude_clipper_unit.sv =====
// tb_iq_magnitude_clipper_unit: stimulus and verdict for the iq magnitude clipper
// depends on iqmc_pkg, iq_magnitude_clipper_unit and iqmc_checker
module tb_iq_magnitude_clipper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0, s_tready, s_tlast = 0;
    logic [31:0] s_tdata = 0;
    logic        m_tvalid, m_tready = 0, m_tlast;
    logic [31:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0, pready;
    logic [iqmc_pkg::APB_AW-1:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic        clip_en = 0;
    logic [23:0] gain = iqmc_pkg::GAIN_RESET;
    int          errors, pending, cycles = 0;
    int          src_idle = 0, snk_idle = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    iq_magnitude_clipper_unit DUT (
        .i_clk, .i_rst_n,
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    iqmc_checker checker_i (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tlast(m_tlast),
        .i_clip_en(clip_en), .i_gain(gain),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_tready <= ($urandom_range(99) >= snk_idle);
        if (cycles > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic reg_write(logic [iqmc_pkg::APB_AW-1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == iqmc_pkg::ADDR_ENABLE) clip_en <= data[0];
        else gain <= data[23:0];
    endtask

    task automatic send_sample(logic [15:0] si, logic [15:0] sq, logic last);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1; s_tdata <= {sq, si}; s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        logic [15:0] si, sq;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(4))
                0: begin si = $urandom; sq = $urandom; end
                1: begin si = $urandom_range(255) - 128; sq = $urandom_range(255) - 128; end
                2: begin si = $urandom; sq = 0; end
                3: begin si = 0; sq = $urandom; end
                default: begin si = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                         sq = $urandom_range(1) ? 16'h8000 : $urandom; end
            endcase
            send_sample(si, sq, $urandom_range(7) == 0);
        end
    endtask

    logic [23:0] gain_set[7] = '{24'd65536, 24'd0, 24'hffffff, 24'd1, 24'd32768,
                                 24'd262144, 24'd70000};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        send_sample(16'h7fff, 16'h8000, 1);
        send_sample(16'h1234, 16'hedcc, 0);
        drain_pipe();
        reg_write(iqmc_pkg::ADDR_ENABLE, 1);
        foreach (gain_set[g]) begin
            reg_write(iqmc_pkg::ADDR_GAIN, gain_set[g]);
            send_sample(16'h0000, 16'h0000, 0);
            send_sample(16'h7fff, 16'h0000, 1);
            send_sample(16'h8000, 16'h0000, 0);
            send_sample(16'h8000, 16'h8000, 1);
            send_sample(16'h0001, 16'h7fff, 0);
            send_sample(16'hffff, 16'h0001, 1);
            drain_pipe();
        end
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
            snk_idle = (ph == 0) ? 54 : (ph == 1) ? 9 : 0;
            for (int r = 0; r < 6; r++) begin
                reg_write(iqmc_pkg::ADDR_ENABLE, (r != 5));
                reg_write(iqmc_pkg::ADDR_GAIN, (r < 2) ? gain_set[$urandom_range(6)]
                                                       : $urandom_range(24'hffffff));
                send_random(90);
                drain_pipe();
            end
        end
        drain_pipe();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
